### rtl/core/bom_sniff_utf16_utf32_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// BOM sniffing decoder - assertion macros
// Shared property shorthands for the checker; clocked on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef BOM_SNIFF_UTF16_UTF32_DECODER_UNIT_ASSERT_SVH
`define BOM_SNIFF_UTF16_UTF32_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define BSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bsd_pkg.sv
// ----------------------------------------------------------------------------
// BOM sniffing decoder - package
// Codes, result entry and the per-byte result bundle passed front to back.
// ----------------------------------------------------------------------------
package bsd_pkg;

  localparam int MAX_RES = 5;                     // results one byte can cause
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int QDEPTH  = 4;                     // power of two
  localparam int QPTR_W  = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    MODE_SNIFF = 3'd0,
    MODE_UTF8  = 3'd1,
    MODE_U16LE = 3'd2,
    MODE_U16BE = 3'd3,
    MODE_U32LE = 3'd4,
    MODE_U32BE = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_UNIT     = 3'd0,
    ST_RAW      = 3'd1,
    ST_END      = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_BAD_SURR = 3'd4,
    ST_BAD_CP   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ENC_UTF8  = 3'd0,
    ENC_U16LE = 3'd1,
    ENC_U16BE = 3'd2,
    ENC_U32LE = 3'd3,
    ENC_U32BE = 3'd4
  } enc_t;

  typedef struct packed {
    logic [15:0] unit;
    status_t     status;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]         cnt;
    enc_t                     enc;
    res_t [MAX_RES-1:0]       ents;
  } bundle_t;

endpackage

### rtl/core/bsd_byte_if.sv
// ----------------------------------------------------------------------------
// BOM sniffing decoder - byte channel
// Valid/ready channel carrying one file byte and its last flag.
// ----------------------------------------------------------------------------
interface bsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

### rtl/core/bsd_unit_if.sv
// ----------------------------------------------------------------------------
// BOM sniffing decoder - result channel
// Valid/ready channel carrying one UTF-16 unit, raw byte, closing or error word.
// ----------------------------------------------------------------------------
interface bsd_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [2:0]  status;
  logic [2:0]  encoding;
  logic        out_last;

  modport source (output valid, output code_unit, output status, output encoding,
                  output out_last, input ready);
  modport sink   (input valid, input code_unit, input status, input encoding,
                  input out_last, output ready);
endinterface

### rtl/core/bom_sniff_utf16_utf32_decoder_unit.sv
// ----------------------------------------------------------------------------
// BOM sniffing UTF-16/UTF-32 decoder - top level
// Sniffs the byte-order mark of a file and emits UTF-16 units or raw bytes.
//
//   channel  dir  word                                 handshake
//   bytes    in   in_byte[8], in_last                  valid/ready
//   units    out  code_unit[16], status[3],            valid/ready
//                 encoding[3], out_last
//
// One byte is taken per cycle while the bundle queue (4 deep) has room.
// A byte's results pass through the bundle queue and the output register,
// one word per cycle while the result port is ready; a byte causing k
// words holds the output for all k, so the output port sets the rate.
// rst is synchronous and leaves the block sniffing a new file.
// Either side may stall; the queue carries the slack between them.
// ----------------------------------------------------------------------------
module bom_sniff_utf16_utf32_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  bsd_byte_if.sink   bytes,
  bsd_unit_if.source units
);
  import bsd_pkg::*;

  logic    push;
  logic    full;
  logic    nempty;
  logic    pop;
  bundle_t f_bundle;
  bundle_t q_head;

  bsd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes),
    .push   (push),
    .bundle (f_bundle),
    .full   (full)
  );

  bsd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (f_bundle),
    .full   (full),
    .pop    (pop),
    .nempty (nempty),
    .dout   (q_head)
  );

  bsd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .nempty (nempty),
    .head   (q_head),
    .pop    (pop),
    .units  (units)
  );

endmodule

### rtl/core/bsd_front.sv
// ----------------------------------------------------------------------------
// BOM sniffing decoder - front end
// Takes one byte a cycle unless full, sniffs the mark, assembles code units,
// checks surrogates and code points, pushes the byte's results as a bundle.
// ----------------------------------------------------------------------------
module bsd_front (
  input  logic             clk,
  input  logic             rst,
  bsd_byte_if.sink         bytes,
  output logic             push,
  output bsd_pkg::bundle_t bundle,
  input  logic             full
);
  import bsd_pkg::*;

  localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
  localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
  localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
  localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
  localparam logic [31:0] CP_MAX        = 32'h0010_FFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h01_0000;
  localparam logic [7:0]  BOM8_0        = 8'hEF;
  localparam logic [7:0]  BOM8_1        = 8'hBB;
  localparam logic [7:0]  BOM8_2        = 8'hBF;
  localparam logic [7:0]  BYTE_FE       = 8'hFE;
  localparam logic [7:0]  BYTE_FF       = 8'hFF;
  localparam logic [7:0]  BYTE_00       = 8'h00;
  localparam int          SNIFF_LEN     = 4;

  typedef struct packed {
    logic [1:0]  cnt;
    res_t        e0;
    res_t        e1;
    logic        err;
    logic        hp;
    logic [15:0] hh;
  } dec_t;

  function automatic dec_t take16(logic [15:0] u, logic hp, logic [15:0] hh);
    dec_t d;
    logic is_high;
    logic is_low;
    is_high = (u >= SURR_HI_FIRST) && (u <= SURR_HI_LAST);
    is_low  = (u >= SURR_LO_FIRST) && (u <= SURR_LO_LAST);
    d    = '0;
    d.hp = hp;
    d.hh = hh;
    if (hp) begin
      if (!is_low) begin
        d.cnt = 2'd1;
        d.e0  = '{unit: 16'h0000, status: ST_BAD_SURR};
        d.err = 1'b1;
      end else begin
        d.cnt = 2'd2;
        d.e0  = '{unit: hh, status: ST_UNIT};
        d.e1  = '{unit: u, status: ST_UNIT};
        d.hp  = 1'b0;
        d.hh  = '0;
      end
    end else if (is_high) begin
      d.hp = 1'b1;
      d.hh = u;
    end else if (is_low) begin
      d.cnt = 2'd1;
      d.e0  = '{unit: 16'h0000, status: ST_BAD_SURR};
      d.err = 1'b1;
    end else begin
      d.cnt = 2'd1;
      d.e0  = '{unit: u, status: ST_UNIT};
    end
    return d;
  endfunction

  function automatic dec_t take32(logic [31:0] cp, logic hp, logic [15:0] hh);
    dec_t        d;
    logic [19:0] v;
    d    = '0;
    d.hp = hp;
    d.hh = hh;
    v    = 20'(cp[20:0] - SUPP_BASE);
    if (cp > CP_MAX ||
        (cp >= {16'h0000, SURR_HI_FIRST} && cp <= {16'h0000, SURR_LO_LAST})) begin
      d.cnt = 2'd1;
      d.e0  = '{unit: 16'h0000, status: ST_BAD_CP};
      d.err = 1'b1;
    end else if (cp[31:16] == 16'h0000) begin
      d.cnt = 2'd1;
      d.e0  = '{unit: cp[15:0], status: ST_UNIT};
    end else begin
      // supplementary point: split into a surrogate pair
      d.cnt = 2'd2;
      d.e0  = '{unit: SURR_HI_FIRST + {6'd0, v[19:10]}, status: ST_UNIT};
      d.e1  = '{unit: SURR_LO_FIRST + {6'd0, v[9:0]}, status: ST_UNIT};
    end
    return d;
  endfunction

  function automatic enc_t enc_of(mode_t m);
    enc_t e;
    unique case (m)
      MODE_U16LE: e = ENC_U16LE;
      MODE_U16BE: e = ENC_U16BE;
      MODE_U32LE: e = ENC_U32LE;
      MODE_U32BE: e = ENC_U32BE;
      default:    e = ENC_UTF8;
    endcase
    return e;
  endfunction

  // decoder state
  mode_t             mode,         mode_next;
  logic [2:0][7:0]   sniff_bytes,  sniff_bytes_next;
  logic [1:0]        sniff_count,  sniff_count_next;
  logic [2:0][7:0]   unit_bytes,   unit_bytes_next;
  logic [1:0]        unit_count,   unit_count_next;
  logic [15:0]       held_high,    held_high_next;
  logic              high_pending, high_pending_next;
  logic              dropping,     dropping_next;

  logic                  acc;
  logic [CNT_W-1:0]      n_res;
  res_t [MAX_RES-1:0]    ents;
  enc_t                  enc_w;
  logic                  err;
  dec_t                  d;
  logic [3:0][7:0]       k;
  logic [2:0]            n;
  logic [2:0]            mark;
  logic [15:0]           u16;
  logic [31:0]           cp32;
  logic                  clr;

  assign bytes.ready = !full;
  assign acc         = bytes.valid && bytes.ready;

  always_comb begin
    mode_next         = mode;
    sniff_bytes_next  = sniff_bytes;
    sniff_count_next  = sniff_count;
    unit_bytes_next   = unit_bytes;
    unit_count_next   = unit_count;
    held_high_next    = held_high;
    high_pending_next = high_pending;
    dropping_next     = dropping;
    n_res = '0;
    ents  = '0;
    err   = 1'b0;
    d     = '0;
    // a byte that completes no unit keeps any held high surrogate
    d.hp  = high_pending;
    d.hh  = held_high;
    k     = {bytes.in_byte, sniff_bytes};
    n     = '0;
    mark  = '0;
    u16   = '0;
    cp32  = '0;
    clr   = 1'b0;
    enc_w = enc_of(mode);

    if (dropping) begin
      if (bytes.in_last) clr = 1'b1;
    end else begin
      if (mode == MODE_SNIFF) begin
        n                = {1'b0, sniff_count} + 3'd1;
        k[sniff_count]   = bytes.in_byte;
        if (n < 3'(SNIFF_LEN) && !bytes.in_last) begin
          sniff_bytes_next[sniff_count] = bytes.in_byte;
          sniff_count_next              = sniff_count + 2'd1;
        end else begin
          if (n >= 3'd3 && k[0] == BOM8_0 && k[1] == BOM8_1 && k[2] == BOM8_2) begin
            mode_next = MODE_UTF8;  mark = 3'd3;
          end else if (n == 3'd4 && k[0] == BYTE_FF && k[1] == BYTE_FE &&
                       k[2] == BYTE_00 && k[3] == BYTE_00) begin
            mode_next = MODE_U32LE; mark = 3'd4;
          end else if (n == 3'd4 && k[0] == BYTE_00 && k[1] == BYTE_00 &&
                       k[2] == BYTE_FE && k[3] == BYTE_FF) begin
            mode_next = MODE_U32BE; mark = 3'd4;
          end else if (n >= 3'd2 && k[0] == BYTE_FF && k[1] == BYTE_FE) begin
            mode_next = MODE_U16LE; mark = 3'd2;
          end else if (n >= 3'd2 && k[0] == BYTE_FE && k[1] == BYTE_FF) begin
            mode_next = MODE_U16BE; mark = 3'd2;
          end else begin
            mode_next = MODE_UTF8;  mark = 3'd0;
          end
          sniff_bytes_next  = '0;
          sniff_count_next  = '0;
          unit_bytes_next   = '0;
          unit_count_next   = '0;
          high_pending_next = 1'b0;
          held_high_next    = '0;
          // buffered bytes after the mark are decoded now
          case (mode_next)
            MODE_UTF8: begin
              for (int i = 0; i < SNIFF_LEN; i++) begin
                if (3'(i) >= mark && 3'(i) < n) begin
                  ents[n_res] = '{unit: {8'h00, k[i]}, status: ST_RAW};
                  n_res       = n_res + CNT_W'(1);
                end
              end
            end
            MODE_U16LE, MODE_U16BE: begin
              if (n == 3'd3) begin
                unit_bytes_next[0] = k[2];
                unit_count_next    = 2'd1;
              end else if (n == 3'd4) begin
                u16 = (mode_next == MODE_U16LE) ? {k[3], k[2]} : {k[2], k[3]};
                d   = take16(u16, 1'b0, 16'h0000);
              end
            end
            default: ;
          endcase
        end
      end else begin
        case (mode)
          MODE_U16LE, MODE_U16BE: begin
            if (unit_count == 2'd0) begin
              unit_bytes_next[0] = bytes.in_byte;
              unit_count_next    = 2'd1;
            end else begin
              unit_count_next = 2'd0;
              u16 = (mode == MODE_U16LE) ? {bytes.in_byte, unit_bytes[0]}
                                         : {unit_bytes[0], bytes.in_byte};
              d   = take16(u16, high_pending, held_high);
            end
          end
          MODE_U32LE, MODE_U32BE: begin
            if (unit_count != 2'd3) begin
              unit_bytes_next[unit_count] = bytes.in_byte;
              unit_count_next             = unit_count + 2'd1;
            end else begin
              unit_count_next = 2'd0;
              cp32 = (mode == MODE_U32LE)
                   ? {bytes.in_byte, unit_bytes[2], unit_bytes[1], unit_bytes[0]}
                   : {unit_bytes[0], unit_bytes[1], unit_bytes[2], bytes.in_byte};
              d    = take32(cp32, high_pending, held_high);
            end
          end
          default: begin
            ents[n_res] = '{unit: {8'h00, bytes.in_byte}, status: ST_RAW};
            n_res       = n_res + CNT_W'(1);
          end
        endcase
      end

      // units from a completed code unit (d is empty otherwise)
      if (d.cnt != 2'd0) begin
        ents[n_res] = d.e0;
        n_res       = n_res + CNT_W'(1);
      end
      if (d.cnt == 2'd2) begin
        ents[n_res] = d.e1;
        n_res       = n_res + CNT_W'(1);
      end
      if (d.cnt != 2'd0 || d.hp != high_pending_next) begin
        high_pending_next = d.hp;
        held_high_next    = d.hh;
      end
      err   = d.err;
      enc_w = enc_of(mode_next);

      if (err) begin
        if (bytes.in_last) clr = 1'b1;
        else               dropping_next = 1'b1;
      end else if (bytes.in_last) begin
        if (unit_count_next != 2'd0) begin
          ents[n_res] = '{unit: 16'h0000, status: ST_BAD_LEN};
        end else if (high_pending_next) begin
          ents[n_res] = '{unit: 16'h0000, status: ST_BAD_SURR};
        end else begin
          ents[n_res] = '{unit: 16'h0000, status: ST_END};
        end
        n_res = n_res + CNT_W'(1);
        clr   = 1'b1;
      end
    end

    if (clr) begin
      mode_next         = MODE_SNIFF;
      sniff_bytes_next  = '0;
      sniff_count_next  = '0;
      unit_bytes_next   = '0;
      unit_count_next   = '0;
      held_high_next    = '0;
      high_pending_next = 1'b0;
      dropping_next     = 1'b0;
    end
  end

  assign push        = acc && (n_res != '0);
  assign bundle.cnt  = n_res;
  assign bundle.enc  = enc_w;
  assign bundle.ents = ents;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_SNIFF;
      sniff_bytes  <= '0;
      sniff_count  <= '0;
      unit_bytes   <= '0;
      unit_count   <= '0;
      held_high    <= '0;
      high_pending <= 1'b0;
      dropping     <= 1'b0;
    end else if (acc) begin
      mode         <= mode_next;
      sniff_bytes  <= sniff_bytes_next;
      sniff_count  <= sniff_count_next;
      unit_bytes   <= unit_bytes_next;
      unit_count   <= unit_count_next;
      held_high    <= held_high_next;
      high_pending <= high_pending_next;
      dropping     <= dropping_next;
    end
  end

endmodule

### rtl/core/bsd_queue.sv
// ----------------------------------------------------------------------------
// BOM sniffing decoder - bundle queue
// Short FIFO of per-byte result bundles between front and back ends.
// ----------------------------------------------------------------------------
module bsd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bsd_pkg::bundle_t din,
  output logic             full,
  input  logic             pop,
  output logic             nempty,
  output bsd_pkg::bundle_t dout
);
  import bsd_pkg::*;

  bundle_t           slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full   = (count == (QPTR_W + 1)'(QDEPTH));
  assign nempty = (count != '0);
  assign dout   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QPTR_W'(1);
      if (pop)  rptr <= rptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/bsd_back.sv
// ----------------------------------------------------------------------------
// BOM sniffing decoder - back end
// Walks the head bundle one entry a cycle into the result register if not stalled.
// ----------------------------------------------------------------------------
module bsd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             nempty,
  input  bsd_pkg::bundle_t head,
  output logic             pop,
  bsd_unit_if.source       units
);
  import bsd_pkg::*;

  logic [CNT_W-1:0] idx;
  res_t             cur;
  logic             load;
  logic             last_ent;

  logic             o_valid;
  logic [15:0]      o_unit;
  logic [2:0]       o_status;
  logic [2:0]       o_enc;
  logic             o_last;

  assign cur      = head.ents[idx];
  assign load     = nempty && (!o_valid || units.ready);
  assign last_ent = (idx == head.cnt - CNT_W'(1));
  assign pop      = load && last_ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      idx     <= '0;
    end else if (load) begin
      o_valid <= 1'b1;
      idx     <= last_ent ? '0 : idx + CNT_W'(1);
    end else if (units.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_unit   <= cur.unit;
      o_status <= cur.status;
      o_enc    <= head.enc;
      // closing and error words end the file
      o_last   <= (cur.status != ST_UNIT) && (cur.status != ST_RAW);
    end
  end

  assign units.valid     = o_valid;
  assign units.code_unit = o_unit;
  assign units.status    = o_status;
  assign units.encoding  = o_enc;
  assign units.out_last  = o_last;

endmodule

### rtl/core/bsd_checker.sv
// ----------------------------------------------------------------------------
// BOM sniffing decoder - port checker
// Watches the result port for word-level rules of the decoder.
// ----------------------------------------------------------------------------
`include "bom_sniff_utf16_utf32_decoder_unit_assert.svh"

module bsd_checker (
  input logic        clk,
  input logic        rst,
  bsd_unit_if.source units
);
  import bsd_pkg::*;

  `BSD_ASSERT_NEXT(a_stall_hold, units.valid && !units.ready, units.valid && $stable(units.code_unit) && $stable(units.status) && $stable(units.encoding) && $stable(units.out_last), "result word changed while stalled")
  `BSD_ASSERT_NOW(a_last_status, units.valid, units.out_last == (units.status >= ST_END), "out_last disagrees with status")
  `BSD_ASSERT_NOW(a_raw_utf8, units.valid && units.status == ST_RAW, units.encoding == ENC_UTF8 && units.code_unit[15:8] == 8'h00, "raw byte outside utf8")
  `BSD_ASSERT_NOW(a_unit_wide, units.valid && units.status == ST_UNIT, units.encoding != ENC_UTF8, "code unit reported as utf8")
  `BSD_ASSERT_NOW(a_close_zero, units.valid && units.out_last, units.code_unit == 16'h0000, "closing word carries data")

endmodule

bind bom_sniff_utf16_utf32_decoder_unit bsd_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .units (units)
);
